// ===== sv/pdst_pkg.sv =====
// shared types and constants for the pid drive controller with slew and heading trim
// used by the front, queue, back and top-level modules; no dependencies

package pdst_pkg;

    // fixed controller constants
    localparam logic [15:0] TICK_MS       = 16'd15;
    localparam logic [31:0] WINDUP_LIMIT  = 32'd85000;
    localparam int          QUEUE_DEPTH   = 4;
    localparam int          QPTR_W        = $clog2(QUEUE_DEPTH);
    localparam int          CFG_ADDR_W    = 5;

    // input kind codes
    localparam logic KIND_START = 1'b0;
    localparam logic KIND_TICK  = 1'b1;

    // configuration register indexes
    localparam logic [2:0] REG_TARGET_TICKS = 3'd0;
    localparam logic [2:0] REG_GAIN_P       = 3'd1;
    localparam logic [2:0] REG_GAIN_I       = 3'd2;
    localparam logic [2:0] REG_GAIN_D       = 3'd3;
    localparam logic [2:0] REG_TIMEOUT_MS   = 3'd4;
    localparam logic [2:0] REG_STOP_BAND    = 3'd5;
    localparam logic [2:0] REG_RISE_STEP    = 3'd6;
    localparam logic [2:0] REG_FALL_STEP    = 3'd7;

    // configuration reset values
    localparam logic [23:0] RST_TARGET_TICKS = 24'd0;
    localparam logic [23:0] RST_GAIN_P       = 24'd214958;
    localparam logic [23:0] RST_GAIN_I       = 24'd398;
    localparam logic [23:0] RST_GAIN_D       = 24'd608174;
    localparam logic [15:0] RST_TIMEOUT_MS   = 16'd3000;
    localparam logic [9:0]  RST_STOP_BAND    = 10'd7;
    localparam logic [7:0]  RST_RISE_STEP    = 8'd9;
    localparam logic [8:0]  RST_FALL_STEP    = 9'd256;

    // classified input item
    typedef struct packed {
        logic               is_start;
        logic signed [23:0] encoder_count;
        logic signed [23:0] heading;
    } item_t;

    // configuration registers as seen by the back end
    typedef struct packed {
        logic signed [23:0] target_ticks;
        logic [23:0]        gain_p;
        logic [23:0]        gain_i;
        logic [23:0]        gain_d;
        logic [15:0]        timeout_ms;
        logic [9:0]         stop_band;
        logic [7:0]         rise_step;
        logic [8:0]         fall_step;
    } cfg_t;

    // one result item
    typedef struct packed {
        logic signed [31:0] integral_sum;
        logic signed [25:0] position_error;
        logic               finished;
        logic signed [7:0]  right_drive;
        logic signed [7:0]  left_drive;
    } result_t;

    // back-end sequencer states
    typedef enum logic [3:0] {
        S_IDLE,
        S_ERR,
        S_SUM,
        S_MUL_P,
        S_MUL_I,
        S_MUL_D,
        S_ACC,
        S_TRIM,
        S_QUOT,
        S_SLEW,
        S_WRITE
    } back_state_t;

endpackage

// ===== sv/pdst_front.sv =====
// input stage: takes stream transfers, decodes the kind and holds one item for the queue
// depends on pdst_pkg

module pdst_front
    import pdst_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [47:0] s_tdata,   // encoder_count[23:0], heading[47:24]
    input  logic [0:0]  s_tuser,   // kind[0]
    output logic        push_valid,
    input  logic        push_ready,
    output item_t       push_item
);

    logic  valid_reg;
    item_t item_reg;

    // the holding register frees up whenever the queue takes its item
    assign s_tready   = !valid_reg || push_ready;
    assign push_valid = valid_reg;
    assign push_item  = item_reg;

    // valid flag
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (s_tready)
        begin
            valid_reg <= s_tvalid;
        end
    end

    // decode and capture the item
    always_ff @(posedge clk)
    begin
        if (s_tvalid && s_tready)
        begin
            item_reg.is_start      <= (s_tuser[0] == KIND_START);
            item_reg.encoder_count <= s_tdata[23:0];
            item_reg.heading       <= s_tdata[47:24];
        end
    end

endmodule

// ===== sv/pdst_queue.sv =====
// short item queue between the input stage and the control back end
// depends on pdst_pkg

module pdst_queue
    import pdst_pkg::*;
(
    input  logic  clk,
    input  logic  rst_n,
    input  logic  push_valid,
    output logic  push_ready,
    input  item_t push_item,
    output logic  pop_valid,
    input  logic  pop,
    output item_t pop_item
);

    item_t             entry_reg [QUEUE_DEPTH];
    logic [QPTR_W-1:0] wr_ptr_reg;
    logic [QPTR_W-1:0] rd_ptr_reg;
    logic [QPTR_W:0]   count_reg;
    logic              do_push;
    logic              do_pop;

    assign push_ready = (count_reg != (QPTR_W + 1)'(QUEUE_DEPTH));
    assign pop_valid  = (count_reg != '0);
    assign pop_item   = entry_reg[rd_ptr_reg];
    assign do_push    = push_valid && push_ready;
    assign do_pop     = pop && pop_valid;

    // pointers and fill count
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (do_push)
            begin
                wr_ptr_reg <= wr_ptr_reg + 1'b1;
            end
            if (do_pop)
            begin
                rd_ptr_reg <= rd_ptr_reg + 1'b1;
            end
            if (do_push && !do_pop)
            begin
                count_reg <= count_reg + 1'b1;
            end
            else if (do_pop && !do_push)
            begin
                count_reg <= count_reg - 1'b1;
            end
        end
    end

    // entry storage
    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            entry_reg[wr_ptr_reg] <= push_item;
        end
    end

endmodule

// ===== sv/pdst_back.sv =====
// control back end: pid sequencer with shared multiplier, heading trim, slew and result register
// depends on pdst_pkg

module pdst_back
    import pdst_pkg::*;
(
    input  logic    clk,
    input  logic    rst_n,
    input  cfg_t    cfg,
    input  logic    q_valid,
    input  item_t   q_item,
    output logic    q_pop,
    output logic    out_valid,
    input  logic    out_ready,
    output result_t out_result
);

    back_state_t        state_reg;
    back_state_t        state_next;

    // controller state
    logic signed [31:0] error_sum_reg;
    logic signed [25:0] last_error_reg;
    logic signed [23:0] start_heading_reg;
    logic signed [23:0] start_count_reg;
    logic [15:0]        elapsed_reg;
    logic signed [7:0]  left_speed_reg;
    logic signed [7:0]  right_speed_reg;
    logic               moving_reg;

    // per-tick working registers
    logic signed [23:0] enc_reg;
    logic signed [23:0] hdg_reg;
    logic signed [25:0] err_reg;
    logic signed [26:0] deriv_reg;
    logic signed [24:0] hdiff_reg;
    logic signed [31:0] sum_reg;
    logic signed [56:0] prod_reg;
    logic signed [57:0] acc_reg;
    logic signed [58:0] lnum_reg;
    logic signed [58:0] rnum_reg;
    logic signed [7:0]  ltgt_reg;
    logic signed [7:0]  rtgt_reg;
    result_t            res_reg;

    // output register
    logic               out_valid_reg;
    result_t            out_data_reg;
    logic               slot_free;

    // combinational datapath
    logic signed [24:0] enc_rel;
    logic signed [25:0] err_calc;
    logic signed [26:0] deriv_calc;
    logic signed [24:0] hdiff_calc;
    logic [16:0]        elapsed_sum;
    logic [15:0]        elapsed_calc;
    logic [25:0]        err_mag;
    logic               done;
    logic signed [32:0] sum_wide;
    logic signed [31:0] sum_sat;
    logic [31:0]        sum_mag;
    logic               windup;
    logic signed [31:0] mul_a;
    logic signed [24:0] mul_b;
    logic signed [56:0] prod_full;
    logic signed [58:0] acc_ext;
    logic signed [58:0] trim_ext;
    logic signed [7:0]  left_new;
    logic signed [7:0]  right_new;

    // truncate toward zero by 2^20, then saturate to +-127
    function automatic logic signed [7:0] quot_clamp(input logic signed [58:0] num);
        logic signed [58:0] biased;
        logic signed [38:0] q;
        biased = num + {39'b0, {20{num[58]}}};
        q      = biased[58:20];
        if (q > 39'sd127)
        begin
            return 8'sd127;
        end
        else if (q < -39'sd127)
        begin
            return -8'sd127;
        end
        return q[7:0];
    endfunction

    // move speed one step toward target, rise step while magnitude grows
    function automatic logic signed [7:0] slew(
        input logic signed [7:0] spd,
        input logic signed [7:0] tgt,
        input logic [7:0]        rise,
        input logic [8:0]        fall
    );
        logic signed [10:0] spd_x;
        logic signed [10:0] tgt_x;
        logic signed [10:0] spd_mag;
        logic signed [10:0] tgt_mag;
        logic signed [10:0] step;
        logic signed [10:0] up;
        logic signed [10:0] dn;
        spd_x   = {{3{spd[7]}}, spd};
        tgt_x   = {{3{tgt[7]}}, tgt};
        spd_mag = spd[7] ? -spd_x : spd_x;
        tgt_mag = tgt[7] ? -tgt_x : tgt_x;
        step    = (spd_mag < tgt_mag) ? {3'b000, rise} : {2'b00, fall};
        up      = spd_x + step;
        dn      = spd_x - step;
        if (tgt_x > up)
        begin
            return up[7:0];
        end
        else if (tgt_x < dn)
        begin
            return dn[7:0];
        end
        return tgt;
    endfunction

    // error, derivative, heading drift and elapsed time
    always_comb
    begin
        enc_rel      = {enc_reg[23], enc_reg} - {start_count_reg[23], start_count_reg};
        err_calc     = {{2{cfg.target_ticks[23]}}, cfg.target_ticks} - {enc_rel[24], enc_rel};
        deriv_calc   = {err_calc[25], err_calc} - {last_error_reg[25], last_error_reg};
        hdiff_calc   = {hdg_reg[23], hdg_reg} - {start_heading_reg[23], start_heading_reg};
        elapsed_sum  = {1'b0, elapsed_reg} + {1'b0, TICK_MS};
        elapsed_calc = elapsed_sum[16] ? 16'hFFFF : elapsed_sum[15:0];
    end

    // end of move test, saturated sum and anti-windup rule
    always_comb
    begin
        err_mag  = err_reg[25] ? -err_reg : err_reg;
        done     = (elapsed_reg >= cfg.timeout_ms) || (err_mag <= {16'b0, cfg.stop_band});
        sum_wide = {error_sum_reg[31], error_sum_reg} + {{7{err_reg[25]}}, err_reg};
        if (sum_wide[32] != sum_wide[31])
        begin
            sum_sat = sum_wide[32] ? 32'sh8000_0000 : 32'sh7FFF_FFFF;
        end
        else
        begin
            sum_sat = sum_wide[31:0];
        end
        sum_mag = sum_sat[31] ? -sum_sat : sum_sat;
        windup  = (err_reg[25] != cfg.target_ticks[23]) || (sum_mag >= WINDUP_LIMIT);
    end

    // shared multiplier operand select
    always_comb
    begin
        case (state_reg)
            S_MUL_P:
            begin
                mul_a = {{6{err_reg[25]}}, err_reg};
                mul_b = {1'b0, cfg.gain_p};
            end
            S_MUL_I:
            begin
                mul_a = sum_reg;
                mul_b = {1'b0, cfg.gain_i};
            end
            S_MUL_D:
            begin
                mul_a = {{5{deriv_reg[26]}}, deriv_reg};
                mul_b = {1'b0, cfg.gain_d};
            end
            default:
            begin
                mul_a = '0;
                mul_b = '0;
            end
        endcase
    end

    assign prod_full = mul_a * mul_b;
    assign acc_ext   = {acc_reg[57], acc_reg};
    assign trim_ext  = {{22{hdiff_reg[24]}}, hdiff_reg, 12'b0};
    assign left_new  = slew(left_speed_reg, ltgt_reg, cfg.rise_step, cfg.fall_step);
    assign right_new = slew(right_speed_reg, rtgt_reg, cfg.rise_step, cfg.fall_step);

    assign slot_free  = !out_valid_reg || out_ready;
    assign q_pop      = (state_reg == S_IDLE) && q_valid;
    assign out_valid  = out_valid_reg;
    assign out_result = out_data_reg;

    // state register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    // next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            S_IDLE:
            begin
                if (q_valid && !q_item.is_start)
                begin
                    state_next = moving_reg ? S_ERR : S_WRITE;
                end
            end
            S_ERR:   state_next = S_SUM;
            S_SUM:   state_next = done ? S_WRITE : S_MUL_P;
            S_MUL_P: state_next = S_MUL_I;
            S_MUL_I: state_next = S_MUL_D;
            S_MUL_D: state_next = S_ACC;
            S_ACC:   state_next = S_TRIM;
            S_TRIM:  state_next = S_QUOT;
            S_QUOT:  state_next = S_SLEW;
            S_SLEW:  state_next = S_WRITE;
            S_WRITE:
            begin
                if (slot_free)
                begin
                    state_next = S_IDLE;
                end
            end
            default: state_next = S_IDLE;
        endcase
    end

    // controller state updates
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            error_sum_reg     <= '0;
            last_error_reg    <= '0;
            start_heading_reg <= '0;
            start_count_reg   <= '0;
            elapsed_reg       <= '0;
            left_speed_reg    <= '0;
            right_speed_reg   <= '0;
            moving_reg        <= 1'b0;
        end
        else
        begin
            case (state_reg)
                S_IDLE:
                begin
                    if (q_valid && q_item.is_start)
                    begin
                        start_count_reg   <= q_item.encoder_count;
                        start_heading_reg <= q_item.heading;
                        error_sum_reg     <= '0;
                        last_error_reg    <= '0;
                        elapsed_reg       <= '0;
                        moving_reg        <= 1'b1;
                    end
                end
                S_ERR:
                begin
                    last_error_reg <= err_calc;
                    elapsed_reg    <= elapsed_calc;
                end
                S_SUM:
                begin
                    if (done)
                    begin
                        error_sum_reg <= sum_sat;
                        moving_reg    <= 1'b0;
                    end
                    else
                    begin
                        error_sum_reg <= windup ? 32'sd0 : sum_sat;
                    end
                end
                S_SLEW:
                begin
                    left_speed_reg  <= left_new;
                    right_speed_reg <= right_new;
                end
                default:
                begin
                end
            endcase
        end
    end

    // per-tick datapath
    always_ff @(posedge clk)
    begin
        case (state_reg)
            S_IDLE:
            begin
                enc_reg <= q_item.encoder_count;
                hdg_reg <= q_item.heading;
                // idle tick reports the held error and sum
                res_reg.left_drive     <= '0;
                res_reg.right_drive    <= '0;
                res_reg.finished       <= 1'b1;
                res_reg.position_error <= last_error_reg;
                res_reg.integral_sum   <= error_sum_reg;
            end
            S_ERR:
            begin
                err_reg   <= err_calc;
                deriv_reg <= deriv_calc;
                hdiff_reg <= hdiff_calc;
            end
            S_SUM:
            begin
                sum_reg                <= windup ? 32'sd0 : sum_sat;
                res_reg.left_drive     <= '0;
                res_reg.right_drive    <= '0;
                res_reg.finished       <= 1'b1;
                res_reg.position_error <= err_reg;
                res_reg.integral_sum   <= sum_sat;
            end
            S_MUL_P:
            begin
                prod_reg <= prod_full;
            end
            S_MUL_I:
            begin
                acc_reg  <= {prod_reg[56], prod_reg};
                prod_reg <= prod_full;
            end
            S_MUL_D:
            begin
                acc_reg  <= acc_reg + {prod_reg[56], prod_reg};
                prod_reg <= prod_full;
            end
            S_ACC:
            begin
                acc_reg <= acc_reg + {prod_reg[56], prod_reg};
            end
            S_TRIM:
            begin
                lnum_reg <= acc_ext - trim_ext;
                rnum_reg <= acc_ext + trim_ext;
            end
            S_QUOT:
            begin
                ltgt_reg <= quot_clamp(lnum_reg);
                rtgt_reg <= quot_clamp(rnum_reg);
            end
            S_SLEW:
            begin
                res_reg.left_drive     <= left_new;
                res_reg.right_drive    <= right_new;
                res_reg.finished       <= 1'b0;
                res_reg.position_error <= err_reg;
                res_reg.integral_sum   <= sum_reg;
            end
            default:
            begin
            end
        endcase
    end

    // result register toward the output stream
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if ((state_reg == S_WRITE) && slot_free)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if ((state_reg == S_WRITE) && slot_free)
        begin
            out_data_reg <= res_reg;
        end
    end

endmodule

// ===== sv/pid_drive_with_slew_and_heading_trim.sv =====
// pid distance drive with heading trim and slew limiting, apb register block on top
// while a move runs, a tick passes the sequencer states idle, err, sum, mul_p, mul_i, mul_d,
// acc, trim, quot, slew and write; a tick that ends the move goes idle, err, sum and write,
// a tick while idle goes idle and write, a start item is taken in idle, and write waits for
// a free result slot; the sequencer has one shared 32x25 multiplier and works one tick at a
// time, and a 4-entry queue absorbs items while a tick is worked on
// reset: rst_n clears all controller state to zero and loads the register defaults
// depends on pdst_pkg, pdst_front, pdst_queue, pdst_back

module pid_drive_with_slew_and_heading_trim
    import pdst_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    // input stream
    input  logic                  s_tvalid,
    output logic                  s_tready,
    input  logic [47:0]           s_tdata,   // encoder_count[23:0], heading[47:24]
    input  logic [0:0]            s_tuser,   // kind[0]
    // result stream
    output logic                  m_tvalid,
    input  logic                  m_tready,
    output logic [79:0]           m_tdata,   // left_drive[7:0], right_drive[15:8],
                                             // finished[16], position_error[42:17],
                                             // integral_sum[74:43], zero[79:75]
    // configuration port
    input  logic                  psel,
    input  logic                  penable,
    input  logic                  pwrite,
    input  logic [CFG_ADDR_W-1:0] paddr,
    input  logic [31:0]           pwdata,
    output logic [31:0]           prdata,
    output logic                  pready
);

    cfg_t       cfg_reg;
    logic       cfg_write;
    logic [2:0] reg_index;
    logic       push_valid;
    logic       push_ready;
    item_t      push_item;
    logic       q_valid;
    logic       q_pop;
    item_t      q_item;
    result_t    result;

    assign pready    = 1'b1;
    assign cfg_write = psel && penable && pwrite && pready;
    assign reg_index = paddr[4:2];

    // configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.target_ticks <= RST_TARGET_TICKS;
            cfg_reg.gain_p       <= RST_GAIN_P;
            cfg_reg.gain_i       <= RST_GAIN_I;
            cfg_reg.gain_d       <= RST_GAIN_D;
            cfg_reg.timeout_ms   <= RST_TIMEOUT_MS;
            cfg_reg.stop_band    <= RST_STOP_BAND;
            cfg_reg.rise_step    <= RST_RISE_STEP;
            cfg_reg.fall_step    <= RST_FALL_STEP;
        end
        else if (cfg_write)
        begin
            case (reg_index)
                REG_TARGET_TICKS: cfg_reg.target_ticks <= pwdata[23:0];
                REG_GAIN_P:       cfg_reg.gain_p       <= pwdata[23:0];
                REG_GAIN_I:       cfg_reg.gain_i       <= pwdata[23:0];
                REG_GAIN_D:       cfg_reg.gain_d       <= pwdata[23:0];
                REG_TIMEOUT_MS:   cfg_reg.timeout_ms   <= pwdata[15:0];
                REG_STOP_BAND:    cfg_reg.stop_band    <= pwdata[9:0];
                REG_RISE_STEP:    cfg_reg.rise_step    <= pwdata[7:0];
                REG_FALL_STEP:    cfg_reg.fall_step    <= pwdata[8:0];
                default:
                begin
                end
            endcase
        end
    end

    // register read back
    always_comb
    begin
        case (reg_index)
            REG_TARGET_TICKS: prdata = {8'b0, cfg_reg.target_ticks};
            REG_GAIN_P:       prdata = {8'b0, cfg_reg.gain_p};
            REG_GAIN_I:       prdata = {8'b0, cfg_reg.gain_i};
            REG_GAIN_D:       prdata = {8'b0, cfg_reg.gain_d};
            REG_TIMEOUT_MS:   prdata = {16'b0, cfg_reg.timeout_ms};
            REG_STOP_BAND:    prdata = {22'b0, cfg_reg.stop_band};
            REG_RISE_STEP:    prdata = {24'b0, cfg_reg.rise_step};
            REG_FALL_STEP:    prdata = {23'b0, cfg_reg.fall_step};
            default:          prdata = '0;
        endcase
    end

    // input stage
    pdst_front u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .s_tvalid   (s_tvalid),
        .s_tready   (s_tready),
        .s_tdata    (s_tdata),
        .s_tuser    (s_tuser),
        .push_valid (push_valid),
        .push_ready (push_ready),
        .push_item  (push_item)
    );

    // item queue
    pdst_queue u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push_valid (push_valid),
        .push_ready (push_ready),
        .push_item  (push_item),
        .pop_valid  (q_valid),
        .pop        (q_pop),
        .pop_item   (q_item)
    );

    // control back end
    pdst_back u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg        (cfg_reg),
        .q_valid    (q_valid),
        .q_item     (q_item),
        .q_pop      (q_pop),
        .out_valid  (m_tvalid),
        .out_ready  (m_tready),
        .out_result (result)
    );

    // result packing
    assign m_tdata = {5'b0, result.integral_sum, result.position_error, result.finished,
                      result.right_drive, result.left_drive};

endmodule

// ===== test/pid_drive_with_slew_and_heading_trim_tb.sv =====
// self-checking testbench for the pid drive controller with heading trim and slew limiting
// drives the input stream and the apb port, predicts every result and checks it on the way out
// depends on pdst_pkg and pid_drive_with_slew_and_heading_trim

module pid_drive_with_slew_and_heading_trim_tb
    import pdst_pkg::*;
();

    timeunit 1ns;
    timeprecision 1ps;

    logic                  clk;
    logic                  rst_n = 1'b0;
    logic                  s_tvalid = 1'b0;
    logic                  s_tready;
    logic [47:0]           s_tdata = '0;    // encoder_count[23:0], heading[47:24]
    logic [0:0]            s_tuser = '0;    // kind[0]
    logic                  m_tvalid;
    logic                  m_tready = 1'b0;
    logic [79:0]           m_tdata;         // left_drive[7:0], right_drive[15:8], finished[16],
                                            // position_error[42:17], integral_sum[74:43]
    logic                  psel = 1'b0;
    logic                  penable = 1'b0;
    logic                  pwrite = 1'b0;
    logic [CFG_ADDR_W-1:0] paddr = '0;
    logic [31:0]           pwdata = '0;
    logic [31:0]           prdata;
    logic                  pready;

    pid_drive_with_slew_and_heading_trim uut (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .psel     (psel),
        .penable  (penable),
        .pwrite   (pwrite),
        .paddr    (paddr),
        .pwdata   (pwdata),
        .prdata   (prdata),
        .pready   (pready)
    );

    // shadow copy of the configuration registers
    logic signed [23:0] cfg_target    = RST_TARGET_TICKS;
    logic [23:0]        cfg_gain_p    = RST_GAIN_P;
    logic [23:0]        cfg_gain_i    = RST_GAIN_I;
    logic [23:0]        cfg_gain_d    = RST_GAIN_D;
    logic [15:0]        cfg_timeout   = RST_TIMEOUT_MS;
    logic [9:0]         cfg_stop_band = RST_STOP_BAND;
    logic [7:0]         cfg_rise      = RST_RISE_STEP;
    logic [8:0]         cfg_fall      = RST_FALL_STEP;

    // predicted controller state
    longint ctl_err_sum   = 0;
    longint ctl_last_err  = 0;
    longint ctl_start_cnt = 0;
    longint ctl_start_hdg = 0;
    int     ctl_elapsed   = 0;
    int     ctl_left      = 0;
    int     ctl_right     = 0;
    bit     ctl_moving    = 1'b0;

    result_t pending_drives[$];

    int  send_idle_pct = 0;
    int  stall_pct = 0;
    logic hold_active = 1'b0;
    int  mismatch_count = 0;
    int  results_checked = 0;
    int  finished_seen = 0;
    int  starts_sent = 0;
    int  ticks_sent = 0;
    int  settings_used = 0;

    // clock
    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // run limit
    initial
    begin
        #5_000_000;
        $display("pid_drive_with_slew_and_heading_trim regression: fail");
        $finish;
    end

    // symmetric random value in -m..m
    function automatic int spread(int m);
        return int'($urandom_range(2 * m)) - m;
    endfunction

    function automatic int clamp_drive(longint v);
        if (v > 127)
            return 127;
        if (v < -127)
            return -127;
        return int'(v);
    endfunction

    // one slew step of a side speed toward its target
    function automatic int slew_toward(int speed, int goal);
        int stride;
        stride = ((speed < 0 ? -speed : speed) < (goal < 0 ? -goal : goal)) ?
                 int'(cfg_rise) : int'(cfg_fall);
        if (goal > speed + stride)
            return speed + stride;
        if (goal < speed - stride)
            return speed - stride;
        return goal;
    endfunction

    // update the predicted state for one accepted item and queue the drive result it causes
    function automatic void predict_drive(logic kind, logic signed [23:0] enc,
                                          logic signed [23:0] hdg);
        longint err, deriv, sum, acc, drift, goal_l, goal_r, enc_l, hdg_l;
        bit done;
        result_t r;
        r = '0;
        enc_l = enc;
        hdg_l = hdg;
        if (kind == KIND_START)
        begin
            ctl_start_cnt = enc_l;
            ctl_start_hdg = hdg_l;
            ctl_err_sum = 0;
            ctl_last_err = 0;
            ctl_elapsed = 0;
            ctl_moving = 1'b1;
            return;
        end
        // idle tick only reports the stored error and sum
        if (!ctl_moving)
        begin
            r.finished = 1'b1;
            r.position_error = ctl_last_err[25:0];
            r.integral_sum = ctl_err_sum[31:0];
            pending_drives.push_back(r);
            return;
        end
        ctl_elapsed = ctl_elapsed + int'(TICK_MS);
        if (ctl_elapsed > 65535)
            ctl_elapsed = 65535;
        err = longint'(cfg_target) - (enc_l - ctl_start_cnt);
        deriv = err - ctl_last_err;
        sum = ctl_err_sum + err;
        if (sum > 64'sd2147483647)
            sum = 64'sd2147483647;
        if (sum < -64'sd2147483648)
            sum = -64'sd2147483648;
        ctl_last_err = err;
        done = (ctl_elapsed >= int'(cfg_timeout)) ||
               ((err < 0 ? -err : err) <= longint'(cfg_stop_band));
        r.position_error = err[25:0];
        if (done)
        begin
            ctl_err_sum = sum;
            ctl_moving = 1'b0;
            r.finished = 1'b1;
            r.integral_sum = sum[31:0];
            pending_drives.push_back(r);
            return;
        end
        // anti-windup: sign flip against the setpoint or too large a sum
        if (((err < 0) != (cfg_target < 0)) ||
            ((sum < 0 ? -sum : sum) >= longint'(WINDUP_LIMIT)))
            sum = 0;
        ctl_err_sum = sum;
        acc = err * longint'(cfg_gain_p) + sum * longint'(cfg_gain_i) +
              deriv * longint'(cfg_gain_d);
        drift = hdg_l - ctl_start_hdg;
        goal_l = (acc - drift * 4096) / 1048576;
        goal_r = (acc + drift * 4096) / 1048576;
        ctl_left = slew_toward(ctl_left, clamp_drive(goal_l));
        ctl_right = slew_toward(ctl_right, clamp_drive(goal_r));
        r.left_drive = ctl_left[7:0];
        r.right_drive = ctl_right[7:0];
        r.integral_sum = sum[31:0];
        pending_drives.push_back(r);
    endfunction

    task automatic report_mismatch(string what, longint got, longint want);
        mismatch_count++;
        if (mismatch_count <= 30)
            $display("mismatch in %s at result %0d: got %0d, expected %0d",
                     what, results_checked, got, want);
    endtask

    // receiver: random stalls, or a long hold-off while pressure is applied
    always @(posedge clk)
    begin
        if (hold_active)
            m_tready <= 1'b0;
        else
            m_tready <= (int'($urandom_range(99)) >= stall_pct);
    end

    // compare each result transfer with the oldest prediction
    always @(posedge clk)
    begin : check_drives
        result_t got, want;
        if (rst_n && m_tvalid && m_tready)
        begin
            got = m_tdata[74:0];
            if (pending_drives.size() == 0)
            begin
                report_mismatch("unexpected result", longint'(got), 0);
            end
            else
            begin
                want = pending_drives.pop_front();
                if (got.left_drive !== want.left_drive)
                    report_mismatch("left_drive", got.left_drive, want.left_drive);
                if (got.right_drive !== want.right_drive)
                    report_mismatch("right_drive", got.right_drive, want.right_drive);
                if (got.finished !== want.finished)
                    report_mismatch("finished", got.finished, want.finished);
                if (got.position_error !== want.position_error)
                    report_mismatch("position_error", got.position_error,
                                    want.position_error);
                if (got.integral_sum !== want.integral_sum)
                    report_mismatch("integral_sum", got.integral_sum, want.integral_sum);
                if (want.finished)
                    finished_seen++;
            end
            results_checked++;
        end
    end

    // one input transfer, with random idle cycles in front of it
    task automatic send_item(logic kind, logic signed [23:0] enc, logic signed [23:0] hdg);
        while (int'($urandom_range(99)) < send_idle_pct)
        begin
            s_tvalid <= 1'b0;
            @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata <= {hdg, enc};
        s_tuser <= kind;
        @(posedge clk);
        while (!s_tready)
            @(posedge clk);
        predict_drive(kind, enc, hdg);
        if (kind == KIND_START)
            starts_sent++;
        else
            ticks_sent++;
    endtask

    // tick whose error and heading drift are set relative to the current move
    task automatic send_tick_near(int err_off, int hdg_off);
        send_item(KIND_TICK, 24'(ctl_start_cnt + longint'(cfg_target) - err_off),
                  24'(ctl_start_hdg + hdg_off));
    endtask

    // apb write: setup then access, then the port is released
    task automatic write_reg(logic [2:0] idx, logic [31:0] value);
        logic [31:0] v;
        case (idx)
            REG_TARGET_TICKS: begin v = value & 32'hFFFFFF; cfg_target = v[23:0]; end
            REG_GAIN_P:       begin v = value & 32'hFFFFFF; cfg_gain_p = v[23:0]; end
            REG_GAIN_I:       begin v = value & 32'hFFFFFF; cfg_gain_i = v[23:0]; end
            REG_GAIN_D:       begin v = value & 32'hFFFFFF; cfg_gain_d = v[23:0]; end
            REG_TIMEOUT_MS:   begin v = value & 32'hFFFF;   cfg_timeout = v[15:0]; end
            REG_STOP_BAND:    begin v = value & 32'h3FF;    cfg_stop_band = v[9:0]; end
            REG_RISE_STEP:    begin v = value & 32'hFF;     cfg_rise = v[7:0]; end
            default:          begin v = value & 32'h1FF;    cfg_fall = v[8:0]; end
        endcase
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b1;
        paddr <= {idx, 2'b00};
        pwdata <= v;
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        while (!pready)
            @(posedge clk);
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
        @(posedge clk);
    endtask

    // stop offering, wait until every predicted result has arrived, let a trailing start settle
    task automatic wait_idle();
        s_tvalid <= 1'b0;
        while (pending_drives.size() != 0)
            @(posedge clk);
        repeat (30) @(posedge clk);
    endtask

    task automatic load_defaults();
        write_reg(REG_TARGET_TICKS, 32'(RST_TARGET_TICKS));
        write_reg(REG_GAIN_P, 32'(RST_GAIN_P));
        write_reg(REG_GAIN_I, 32'(RST_GAIN_I));
        write_reg(REG_GAIN_D, 32'(RST_GAIN_D));
        write_reg(REG_TIMEOUT_MS, 32'(RST_TIMEOUT_MS));
        write_reg(REG_STOP_BAND, 32'(RST_STOP_BAND));
        write_reg(REG_RISE_STEP, 32'(RST_RISE_STEP));
        write_reg(REG_FALL_STEP, 32'(RST_FALL_STEP));
    endtask

    task automatic set_idling(int send_pct, int recv_pct);
        send_idle_pct = send_pct;
        stall_pct <= recv_pct;
    endtask

    // tick before any start, then a short move on the reset register values
    task automatic test_idle_and_defaults();
        send_item(KIND_TICK, -24'sd8388608, 24'sd8388607);
        send_item(KIND_START, 24'sd5000, 24'sd1000);
        send_item(KIND_TICK, 24'sd4700, 24'sd3560);
        send_item(KIND_TICK, 24'sd4800, 24'sd500);
        send_item(KIND_TICK, 24'sd5003, 24'sd1000);
        send_item(KIND_TICK, 24'sd5003, 24'sd1000);
    endtask

    // widest registers and inputs, saturated targets
    task automatic test_register_extremes();
        wait_idle();
        write_reg(REG_TARGET_TICKS, 32'h7FFFFF);
        write_reg(REG_GAIN_P, 32'hFFFFFF);
        write_reg(REG_GAIN_I, 32'hFFFFFF);
        write_reg(REG_GAIN_D, 32'hFFFFFF);
        write_reg(REG_TIMEOUT_MS, 32'hFFFF);
        write_reg(REG_STOP_BAND, 32'd0);
        write_reg(REG_RISE_STEP, 32'hFF);
        write_reg(REG_FALL_STEP, 32'h1FF);
        send_item(KIND_START, -24'sd8388608, -24'sd8388608);
        send_item(KIND_TICK, 24'sd8388607, 24'sd8388607);
        send_item(KIND_TICK, -24'sd8388608, -24'sd8388608);
        send_item(KIND_TICK, -24'sd1, 24'sd0);
        wait_idle();
        write_reg(REG_TARGET_TICKS, 32'h800000);
        send_item(KIND_START, 24'sd8388607, 24'sd0);
        send_item(KIND_TICK, -24'sd8388608, 24'sd0);
    endtask

    // sum cleared past the windup limit and on a sign flip, zero error counts as positive
    task automatic test_windup_and_sign();
        wait_idle();
        load_defaults();
        write_reg(REG_TARGET_TICKS, 32'd60000);
        send_item(KIND_START, 24'sd0, 24'sd0);
        send_item(KIND_TICK, 24'sd0, 24'sd0);
        send_item(KIND_TICK, 24'sd0, 24'sd0);
        send_item(KIND_TICK, 24'sd70000, 24'sd0);
        send_item(KIND_TICK, 24'sd60000, 24'sd0);
        wait_idle();
        write_reg(REG_TARGET_TICKS, 32'd0);
        write_reg(REG_STOP_BAND, 32'd0);
        send_item(KIND_START, 24'sd100, 24'sd0);
        send_item(KIND_TICK, 24'sd150, -24'sd255);
        send_item(KIND_TICK, 24'sd100, 24'sd0);
    endtask

    // immediate timeout, band edges, restart in the middle of a move
    task automatic test_timeout_band_restart();
        wait_idle();
        write_reg(REG_TIMEOUT_MS, 32'd0);
        send_item(KIND_START, 24'sd0, 24'sd0);
        send_item(KIND_TICK, 24'sd12, 24'sd0);
        wait_idle();
        write_reg(REG_TIMEOUT_MS, 32'd30);
        write_reg(REG_STOP_BAND, 32'd1023);
        write_reg(REG_TARGET_TICKS, 32'd2000);
        send_item(KIND_START, 24'sd0, 24'sd0);
        send_item(KIND_TICK, 24'sd976, 24'sd256);
        send_item(KIND_START, 24'sd0, 24'sd0);
        send_item(KIND_TICK, 24'sd0, 24'sd0);
        send_item(KIND_TICK, 24'sd0, 24'sd0);
    endtask

    // frozen speeds with zero steps, then a rise step of three and a fall step of one
    task automatic test_slew_limits();
        wait_idle();
        load_defaults();
        write_reg(REG_TARGET_TICKS, 32'd400);
        write_reg(REG_RISE_STEP, 32'd0);
        write_reg(REG_FALL_STEP, 32'd0);
        send_item(KIND_START, 24'sd0, 24'sd0);
        send_item(KIND_TICK, 24'sd0, 24'sd9000);
        wait_idle();
        write_reg(REG_RISE_STEP, 32'd3);
        write_reg(REG_FALL_STEP, 32'd1);
        send_item(KIND_TICK, 24'sd100, -24'sd9000);
    endtask

    // receiver held off for a long stretch while ticks keep coming
    task automatic test_backpressure();
        wait_idle();
        load_defaults();
        write_reg(REG_TARGET_TICKS, 32'd900);
        set_idling(0, 0);
        send_item(KIND_START, 24'($urandom), 24'($urandom));
        fork
            begin
                hold_active <= 1'b1;
                repeat (300) @(posedge clk);
                hold_active <= 1'b0;
            end
        join_none
        for (int n = 0; n < 24; n++)
            send_tick_near(900 - 35 * n, spread(3000));
    endtask

    // random registers, mostly near working values, sometimes anywhere
    task automatic shuffle_settings();
        int pick;
        wait_idle();
        pick = $urandom_range(3);
        write_reg(REG_TARGET_TICKS, pick == 0 ? 32'd0 :
                                    pick == 1 ? $urandom : spread(5000));
        pick = $urandom_range(5);
        write_reg(REG_GAIN_P, pick == 0 ? $urandom : $urandom_range(600000));
        write_reg(REG_GAIN_I, pick == 0 ? $urandom : $urandom_range(4000));
        write_reg(REG_GAIN_D, pick == 0 ? $urandom : $urandom_range(1500000));
        write_reg(REG_TIMEOUT_MS, $urandom_range(45, 1200));
        write_reg(REG_STOP_BAND, pick == 1 ? $urandom_range(1023) : $urandom_range(40));
        write_reg(REG_RISE_STEP, $urandom_range(255));
        write_reg(REG_FALL_STEP, $urandom_range(511));
        settings_used++;
    endtask

    // mostly converging moves with random content, plus stray starts and noise ticks
    task automatic run_random_moves(int count);
        int pick, walk_err, hdg_off;
        walk_err = int'(cfg_target);
        for (int n = 0; n < count; n++)
        begin
            pick = $urandom_range(99);
            if (pick < 6)
            begin
                send_item(KIND_START, 24'($urandom), pick < 3 ? 24'($urandom) : 24'(spread(500)));
                walk_err = int'(cfg_target) + spread(30);
            end
            else if (pick < 14)
            begin
                send_item(KIND_TICK, 24'($urandom), 24'($urandom));
            end
            else
            begin
                if (pick < 18)
                    walk_err = spread(70000);
                else
                    walk_err = walk_err - walk_err / 4 + spread(20);
                hdg_off = (pick < 30) ? spread(40000) : spread(600);
                send_tick_near(walk_err, hdg_off);
            end
        end
    endtask

    // four idling phases, two register settings each
    task automatic test_random_phases();
        int send_pcts[4] = '{0, 71, 0, 18};
        int recv_pcts[4] = '{0, 0, 71, 18};
        for (int p = 0; p < 4; p++)
        begin
            for (int half = 0; half < 2; half++)
            begin
                shuffle_settings();
                set_idling(send_pcts[p], recv_pcts[p]);
                run_random_moves(100);
            end
        end
    endtask

    initial
    begin
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        set_idling(0, 0);
        test_idle_and_defaults();
        test_register_extremes();
        test_windup_and_sign();
        test_timeout_band_restart();
        test_slew_limits();
        test_backpressure();
        test_random_phases();
        s_tvalid <= 1'b0;
        while (pending_drives.size() != 0)
            @(posedge clk);
        repeat (40) @(posedge clk);
        $display("covered %0d start and %0d tick transfers under %0d random register settings",
                 starts_sent, ticks_sent, settings_used);
        $display("checked %0d results, %0d of them with the move finished, %0d mismatches",
                 results_checked, finished_seen, mismatch_count);
        if (mismatch_count == 0)
            $display("pid_drive_with_slew_and_heading_trim regression: pass");
        else
            $display("pid_drive_with_slew_and_heading_trim regression: fail");
        $finish;
    end

endmodule
